/* rtl/swerve_inverse_kinematics_defines.svh */
// Assertion macros shared by the swerve inverse kinematics RTL.
`ifndef SWERVE_INVERSE_KINEMATICS_DEFINES_SVH
`define SWERVE_INVERSE_KINEMATICS_DEFINES_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define SWIK_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk_i outside reset.
`define SWIK_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/swik_pkg.sv */
// Types, constants and the arctangent table of the swerve inverse kinematics block.
package swik_pkg;

  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned InvRadW     = 26;
  localparam int unsigned CordicIters = 30;

  localparam logic [CfgIdxW-1:0] REG_WHEEL0_X   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_WHEEL0_Y   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_WHEEL1_X   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_WHEEL1_Y   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INV_RADIUS = 3'd4;

  localparam logic [InvRadW-1:0] INV_RADIUS_RST = 26'd655360;

  localparam logic signed [31:0] PI_Q29      = 32'sd1686629713;
  localparam logic signed [31:0] HALF_PI_Q29 = 32'sd843314857;
  localparam logic signed [32:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [32:0] FLIP_LIM    = 33'sd843314856;
  localparam logic [31:0]        SLOW_LIM    = 32'd65;
  localparam logic [31:0]        SPEED_MAX   = 32'h7fff_ffff;

  typedef struct packed {
    logic signed [31:0] body_vx;
    logic signed [31:0] body_vy;
    logic signed [31:0] body_wz;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] angle0;
    logic signed [31:0] speed0;
    logic signed [31:0] angle1;
    logic signed [31:0] speed1;
  } out_word_t;

  // Angle of one rotation step in Q2.30.
  function automatic logic signed [32:0] atan_step(input logic [4:0] idx);
    logic signed [32:0] s;
    case (idx)
      5'd0:    s = 33'sd843314856;
      5'd1:    s = 33'sd497837829;
      5'd2:    s = 33'sd263043836;
      5'd3:    s = 33'sd133525158;
      5'd4:    s = 33'sd67021686;
      5'd5:    s = 33'sd33543515;
      5'd6:    s = 33'sd16775850;
      5'd7:    s = 33'sd8388437;
      5'd8:    s = 33'sd4194282;
      5'd9:    s = 33'sd2097149;
      default: s = (33'sd1 <<< (5'd30 - idx)) - 33'sd1;
    endcase
    return s;
  endfunction

endpackage

/* rtl/swik_stream_if.sv */
// Valid/ready channel that carries one word of a given payload type.
interface swik_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/swerve_inverse_kinematics.sv */
// Swerve drive inverse kinematics for two wheels: steer angles and signed wheel speeds.
// From the acceptance of a command word until its result word has been taken, no new
// command is taken. The wheels are worked one after the other. Per wheel, one shared
// 33x33 multiplier forms the lever-arm products, the squares and the radius scaling,
// the normalizing shift takes one bit a cycle, and the square root gives one bit a
// cycle. The CORDIC unit runs alongside the root; for small wheel vectors its
// normalization can make it finish after the root, and then the wheel waits for it.
`include "swerve_inverse_kinematics_defines.svh"

module swerve_inverse_kinematics #(
  parameter int unsigned NUM_WHEELS = 2
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [swik_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [31:0]                     cfg_data_i,
  swik_stream_if.sink                     in_i,
  swik_stream_if.source                   out_o
);
  import swik_pkg::*;

  localparam int unsigned WheelW = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_MY   = 5'd1;
  localparam logic [4:0] S_MX   = 5'd2;
  localparam logic [4:0] S_WY   = 5'd3;
  localparam logic [4:0] S_ABS  = 5'd4;
  localparam logic [4:0] S_SH   = 5'd5;
  localparam logic [4:0] S_SQA  = 5'd6;
  localparam logic [4:0] S_SQB  = 5'd7;
  localparam logic [4:0] S_SUM  = 5'd8;
  localparam logic [4:0] S_RST  = 5'd9;
  localparam logic [4:0] S_ROOT = 5'd10;
  localparam logic [4:0] S_SPM  = 5'd11;
  localparam logic [4:0] S_SPS  = 5'd12;
  localparam logic [4:0] S_SPD  = 5'd13;
  localparam logic [4:0] S_WAIT = 5'd14;
  localparam logic [4:0] S_FIN  = 5'd15;
  localparam logic [4:0] S_OUT  = 5'd16;

  logic [4:0]          state_q;
  logic [4:0]          state_d;
  logic [WheelW-1:0]   wheel_q;

  logic signed [31:0]  pos_x_q [NUM_WHEELS];
  logic signed [31:0]  pos_y_q [NUM_WHEELS];
  logic [InvRadW-1:0]  inv_r_q;
  logic signed [31:0]  last_q [NUM_WHEELS];

  in_word_t            cmd_q;
  logic signed [47:0]  wx_q;
  logic signed [47:0]  wy_q;
  logic [47:0]         a_q;
  logic [47:0]         b_q;
  logic [4:0]          s_q;
  logic [63:0]         sum_q;
  logic [74:0]         prod_q;
  logic [31:0]         spd_q;
  logic signed [31:0]  ang_q [NUM_WHEELS];
  logic signed [31:0]  vel_q [NUM_WHEELS];

  logic signed [32:0]  mul_a;
  logic signed [32:0]  mul_b;
  logic signed [65:0]  mul_q;
  logic signed [47:0]  lever;
  logic [47:0]         abs_x;
  logic [47:0]         abs_y;
  logic [47:0]         or_ab;

  logic                sq_start;
  logic                sq_busy;
  logic [31:0]         root;
  logic                cd_start;
  logic                cd_busy;
  logic [31:0]         theta;

  logic [75:0]         rnd_sum;
  logic                moving;
  logic signed [31:0]  last_cur;
  logic signed [31:0]  ang_fwd;
  logic signed [31:0]  ang_rev;
  logic signed [32:0]  diff;
  logic                flip;

  function automatic logic signed [31:0] place_quadrant(input logic [31:0] t,
                                                        input logic xn,
                                                        input logic yn);
    logic signed [31:0] tt;
    tt = xn ? (PI_Q29 - signed'(t)) : signed'(t);
    return yn ? -tt : tt;
  endfunction

  // Rounded Q16.16 lever-arm term taken from the multiplier register.
  assign lever = 48'((mul_q[63:0] + 64'sd32768) >>> 16);
  assign abs_x = wx_q[47] ? 48'(-wx_q) : 48'(wx_q);
  assign abs_y = wy_q[47] ? 48'(-wy_q) : 48'(wy_q);
  assign or_ab = a_q | b_q;
  assign rnd_sum = {1'b0, prod_q} + 76'd32768;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_MY: begin
        mul_a = 33'(cmd_q.body_wz);
        mul_b = 33'(pos_y_q[wheel_q]);
      end
      S_MX: begin
        mul_a = 33'(cmd_q.body_wz);
        mul_b = 33'(pos_x_q[wheel_q]);
      end
      S_SQA: begin
        mul_a = signed'({2'b00, a_q[30:0]});
        mul_b = signed'({2'b00, a_q[30:0]});
      end
      S_SQB: begin
        mul_a = signed'({2'b00, b_q[30:0]});
        mul_b = signed'({2'b00, b_q[30:0]});
      end
      S_SPM: begin
        mul_a = signed'({1'b0, root});
        mul_b = signed'({7'b0, inv_r_q});
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    mul_q <= mul_a * mul_b;
  end

  assign sq_start = (state_q == S_RST);
  assign cd_start = (state_q == S_ABS);

  swik_isqrt u_isqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (sum_q),
    .busy_o     (sq_busy),
    .root_o     (root)
  );

  swik_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cd_start),
    .mag_x_i (abs_x),
    .mag_y_i (abs_y),
    .busy_o  (cd_busy),
    .angle_o (theta)
  );

  assign moving   = (spd_q > SLOW_LIM);
  assign last_cur = last_q[wheel_q];
  assign ang_fwd  = moving ? place_quadrant(theta, wx_q < 0, wy_q < 0) : last_cur;
  assign ang_rev  = place_quadrant(theta, wx_q > 0, wy_q > 0);
  assign diff     = 33'(ang_fwd) - 33'(last_cur);
  assign flip     = (diff > FLIP_LIM) || (diff < -FLIP_LIM);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_i.valid) state_d = S_MY;
      S_MY:   state_d = S_MX;
      S_MX:   state_d = S_WY;
      S_WY:   state_d = S_ABS;
      S_ABS:  state_d = S_SH;
      S_SH:   if (!(|or_ab[47:31])) state_d = S_SQA;
      S_SQA:  state_d = S_SQB;
      S_SQB:  state_d = S_SUM;
      S_SUM:  state_d = S_RST;
      S_RST:  state_d = S_ROOT;
      S_ROOT: if (!sq_busy) state_d = S_SPM;
      S_SPM:  state_d = S_SPS;
      S_SPS:  state_d = S_SPD;
      S_SPD:  state_d = S_WAIT;
      S_WAIT: if (!cd_busy) state_d = S_FIN;
      S_FIN: begin
        if (wheel_q == WheelW'(NUM_WHEELS - 1)) begin
          state_d = S_OUT;
        end else begin
          state_d = S_MY;
        end
      end
      S_OUT:  if (out_o.ready) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      wheel_q <= '0;
      inv_r_q <= INV_RADIUS_RST;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        pos_x_q[w] <= '0;
        pos_y_q[w] <= '0;
        last_q[w]  <= '0;
      end
    end else begin
      state_q <= state_d;
      if (state_q == S_IDLE) begin
        wheel_q <= '0;
      end else if (state_q == S_FIN) begin
        last_q[wheel_q] <= flip ? ang_rev : ang_fwd;
        wheel_q <= wheel_q + WheelW'(1);
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WHEEL0_X:   pos_x_q[0] <= cfg_data_i;
          REG_WHEEL0_Y:   pos_y_q[0] <= cfg_data_i;
          REG_WHEEL1_X:   pos_x_q[1] <= cfg_data_i;
          REG_WHEEL1_Y:   pos_y_q[1] <= cfg_data_i;
          REG_INV_RADIUS: inv_r_q    <= cfg_data_i[InvRadW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: if (in_i.valid) cmd_q <= in_i.data;
      S_MX:   wx_q <= 48'(cmd_q.body_vx) - lever;
      S_WY:   wy_q <= 48'(cmd_q.body_vy) + lever;
      S_ABS: begin
        a_q <= abs_x;
        b_q <= abs_y;
        s_q <= '0;
      end
      S_SH: begin
        if (|or_ab[47:31]) begin
          a_q <= a_q >> 1;
          b_q <= b_q >> 1;
          s_q <= s_q + 5'd1;
        end
      end
      S_SQB:  sum_q <= 64'(mul_q);
      S_SUM:  sum_q <= sum_q + 64'(mul_q);
      S_SPS:  prod_q <= {17'b0, mul_q[57:0]} << s_q;
      S_SPD:  spd_q <= (|rnd_sum[75:47]) ? SPEED_MAX : rnd_sum[47:16];
      S_FIN: begin
        ang_q[wheel_q] <= flip ? ang_rev : ang_fwd;
        vel_q[wheel_q] <= flip ? -signed'(spd_q) : signed'(spd_q);
      end
      default: begin
      end
    endcase
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = (state_q == S_OUT);
  assign out_o.data.angle0  = ang_q[0];
  assign out_o.data.speed0  = vel_q[0];
  assign out_o.data.angle1  = ang_q[1];
  assign out_o.data.speed1  = vel_q[1];

  `SWIK_ASSERT_IMPL(a_sides_exclusive, in_i.ready, !out_o.valid, "Input and output open together.")
  `SWIK_ASSERT_NEXT(a_accept_starts, in_i.valid && in_i.ready, state_q == S_MY && wheel_q == '0, "Accepted word did not start wheel zero.")
  `SWIK_ASSERT_IMPL(a_angle_range, out_o.valid, out_o.data.angle0 <= PI_Q29 && out_o.data.angle0 >= -PI_Q29 && out_o.data.angle1 <= PI_Q29 && out_o.data.angle1 >= -PI_Q29, "Steer angle outside plus or minus pi.")
  `SWIK_ASSERT_IMPL(a_speed_sat, out_o.valid, out_o.data.speed0 != 32'sh8000_0000 && out_o.data.speed1 != 32'sh8000_0000, "Wheel speed escaped saturation.")
endmodule

/* rtl/swik_isqrt.sv */
// Bit-serial integer square root of a 64-bit radicand, one result bit per cycle.
module swik_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        busy_o,
  output logic [31:0] root_o
);
  logic        busy_q;
  logic [63:0] rem_q;
  logic [63:0] res_q;
  logic [63:0] bit_q;
  logic [63:0] trial;

  assign trial = res_q + bit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (busy_q && bit_q[0]) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= radicand_i;
      res_q <= '0;
      bit_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (rem_q >= trial) begin
        rem_q <= rem_q - trial;
        res_q <= (res_q >> 1) + bit_q;
      end else begin
        res_q <= res_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  assign busy_o = busy_q;
  assign root_o = res_q[31:0];
endmodule

/* rtl/swik_cordic.sv */
// First-quadrant arctangent of two magnitudes by normalization and CORDIC vectoring.
module swik_cordic (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] mag_x_i,
  input  logic [47:0] mag_y_i,
  output logic        busy_o,
  output logic [31:0] angle_o
);
  import swik_pkg::*;

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_NORM = 2'd1;
  localparam logic [1:0] C_ITER = 2'd2;
  localparam logic [1:0] C_FIN  = 2'd3;

  logic [1:0]         state_q;
  logic [1:0]         state_d;
  logic signed [47:0] x_q;
  logic signed [47:0] y_q;
  logic signed [32:0] z_q;
  logic [4:0]         i_q;
  logic [31:0]        t_q;
  logic [47:0]        or_xy;
  logic signed [47:0] dx;
  logic signed [47:0] dy;
  logic signed [32:0] step;
  logic signed [32:0] z_clamp;
  logic               norm_done;

  assign or_xy     = x_q | y_q;
  assign norm_done = !(|or_xy[47:30]) && or_xy[29];
  assign dx        = y_q >>> i_q;
  assign dy        = x_q >>> i_q;
  assign step      = atan_step(i_q);

  always_comb begin
    if (z_q < 0) begin
      z_clamp = '0;
    end else if (z_q > HALF_PI_Q30) begin
      z_clamp = HALF_PI_Q30;
    end else begin
      z_clamp = z_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      C_IDLE: begin
        if (start_i && (mag_x_i != '0) && (mag_y_i != '0)) begin
          state_d = C_NORM;
        end
      end
      C_NORM: begin
        if (norm_done) begin
          state_d = C_ITER;
        end
      end
      C_ITER: begin
        if (i_q == 5'(CordicIters - 1)) begin
          state_d = C_FIN;
        end
      end
      C_FIN: state_d = C_IDLE;
      default: state_d = C_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (start_i) begin
          x_q <= signed'(mag_x_i);
          y_q <= signed'(mag_y_i);
          if (mag_y_i == '0) begin
            t_q <= '0;
          end else if (mag_x_i == '0) begin
            t_q <= unsigned'(HALF_PI_Q29);
          end
        end
      end
      C_NORM: begin
        if (|or_xy[47:30]) begin
          x_q <= x_q >>> 1;
          y_q <= y_q >>> 1;
        end else if (!or_xy[29]) begin
          x_q <= x_q <<< 1;
          y_q <= y_q <<< 1;
        end else begin
          z_q <= '0;
          i_q <= '0;
        end
      end
      C_ITER: begin
        if (y_q > 0) begin
          x_q <= x_q + dx;
          y_q <= y_q - dy;
          z_q <= z_q + step;
        end else begin
          x_q <= x_q - dx;
          y_q <= y_q + dy;
          z_q <= z_q - step;
        end
        i_q <= i_q + 5'd1;
      end
      C_FIN: begin
        t_q <= 32'((z_clamp + 33'sd1) >>> 1);
      end
      default: begin
      end
    endcase
  end

  assign busy_o  = (state_q != C_IDLE);
  assign angle_o = t_q;
endmodule

/* tb/sv/tb_swerve_inverse_kinematics.sv */
// Self-checking testbench for the two-wheel swerve inverse kinematics block.
`timescale 1ns / 1ps

module tb_swerve_inverse_kinematics;
  import swik_pkg::*;

  typedef struct {
    in_word_t  cmd;
    bit        typed;
    out_word_t want;
  } cmd_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [31:0]         cfg_data_i;

  swik_stream_if #(.T(in_word_t))  cmd_if ();
  swik_stream_if #(.T(out_word_t)) wheel_if ();

  swerve_inverse_kinematics DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (cmd_if),
    .out_o      (wheel_if)
  );

  logic signed [31:0] wheel_pos [4];
  logic [25:0]        inv_radius;
  longint             prev_angle [2];
  out_word_t          pending_wheels [$];
  int                 errors;
  int                 idle_mode;
  bit                 hold_req;
  int                 hold_left;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #5ms;
    $display("[swerve_inverse_kinematics] ERROR");
    $finish;
  end

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    errors++;
  endtask

  function automatic longint unsigned int_sqrt(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint steer_atan(input longint unsigned a, input longint unsigned b,
                                        input bit xneg, input bit yneg);
    longint head [10];
    longint x, y, z, t, st, dx, dy;
    head = '{843314856, 497837829, 263043836, 133525158, 67021686,
             33543515, 16775850, 8388437, 4194282, 2097149};
    if (b == 0) begin
      t = 0;
    end else if (a == 0) begin
      t = HALF_PI_Q29;
    end else begin
      while ((a | b) >= 64'd1 << 30) begin
        a >>= 1;
        b >>= 1;
      end
      while ((a | b) < 64'd1 << 29) begin
        a <<= 1;
        b <<= 1;
      end
      x = a;
      y = b;
      z = 0;
      for (int i = 0; i < CordicIters; i++) begin
        st = (i < 10) ? head[i] : ((64'sd1 <<< (30 - i)) - 1);
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx;
          y -= dy;
          z += st;
        end else begin
          x -= dx;
          y += dy;
          z -= st;
        end
      end
      if (z < 0) z = 0;
      if (z > HALF_PI_Q30) z = HALF_PI_Q30;
      t = (z + 1) >>> 1;
    end
    if (xneg) t = PI_Q29 - t;
    if (yneg) t = -t;
    return t;
  endfunction

  function automatic void steer_wheel(input longint vx, input longint vy, input longint wz,
                                      input int w, output logic [31:0] ang,
                                      output logic [31:0] spd);
    longint rx, ry, wx, wy, angle, speed, diff;
    longint unsigned a, b, mag, sp;
    int s;
    bit moving;
    rx = wheel_pos[2 * w];
    ry = wheel_pos[2 * w + 1];
    wx = vx - ((wz * ry + 32768) >>> 16);
    wy = vy + ((wz * rx + 32768) >>> 16);
    a = (wx < 0) ? -wx : wx;
    b = (wy < 0) ? -wy : wy;
    s = 0;
    while (((a >> s) | (b >> s)) >= 64'd1 << 31) s++;
    mag = int_sqrt((a >> s) * (a >> s) + (b >> s) * (b >> s)) << s;
    sp = mag * (inv_radius >> 16) + ((mag * (inv_radius & 26'hffff) + 32768) >> 16);
    if (sp > SPEED_MAX) sp = SPEED_MAX;
    moving = sp > SLOW_LIM;
    angle = moving ? steer_atan(a, b, wx < 0, wy < 0) : prev_angle[w];
    speed = sp;
    diff = angle - prev_angle[w];
    if (diff > FLIP_LIM || diff < -FLIP_LIM) begin
      angle = moving ? steer_atan(a, b, wx > 0, wy > 0) : prev_angle[w];
      speed = -speed;
    end
    prev_angle[w] = angle;
    ang = angle[31:0];
    spd = speed[31:0];
  endfunction

  function automatic out_word_t predict_wheels(input in_word_t c);
    out_word_t o;
    steer_wheel(c.body_vx, c.body_vy, c.body_wz, 0, o.angle0, o.speed0);
    steer_wheel(c.body_vx, c.body_vy, c.body_wz, 1, o.angle1, o.speed1);
    return o;
  endfunction

  // Leaves the write enable high; the caller drops it after the last write.
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [31:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    if (idx == REG_INV_RADIUS) inv_radius = value[25:0];
    else wheel_pos[idx[1:0]] = value;
  endtask

  task automatic send_cmd(input in_word_t c, input bit typed, input out_word_t want);
    out_word_t got_pred;
    bit gap;
    gap = (idle_mode == 1) ? ($urandom_range(0, 99) < 46) :
          (idle_mode == 3) ? ($urandom_range(0, 99) < 10) : 1'b0;
    if (gap) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    cmd_if.valid <= 1'b1;
    cmd_if.data  <= c;
    @(posedge clk_i);
    while (!cmd_if.ready) @(posedge clk_i);
    got_pred = predict_wheels(c);
    pending_wheels.push_back(typed ? want : got_pred);
  endtask

  task automatic drain_results();
    cmd_if.valid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_velocity();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 393216) - 196608;
    if (pick < 75) return $urandom_range(0, 400) - 200;
    if (pick < 90) return $urandom;
    return 0;
  endfunction

  initial begin
    automatic cmd_row_t rows [$];
    automatic out_word_t none = '0;
    automatic in_word_t c;
    automatic in_word_t last_cmd = '0;
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_data_i   = '0;
    cmd_if.valid = 1'b0;
    cmd_if.data  = '0;
    errors       = 0;
    idle_mode    = 0;
    hold_req     = 1'b0;
    wheel_pos    = '{default: '0};
    inv_radius   = INV_RADIUS_RST;
    prev_angle   = '{default: 0};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rows.push_back('{'{0, 0, 0}, 1, '{0, 0, 0, 0}});
    rows.push_back('{'{65536, 0, 0}, 1, '{0, 655360, 0, 655360}});
    rows.push_back('{'{-65536, 0, 0}, 1, '{0, -655360, 0, -655360}});
    rows.push_back('{'{32'sh7fffffff, 0, 0}, 1, '{0, 32'sh7fffffff, 0, 32'sh7fffffff}});
    rows.push_back('{'{32'sh80000000, 0, 0}, 1, '{0, 32'sh80000001, 0, 32'sh80000001}});
    rows.push_back('{'{0, 65536, 0}, 0, none});
    rows.push_back('{'{0, -65536, 0}, 0, none});
    rows.push_back('{'{0, 0, 65536}, 0, none});
    rows.push_back('{'{65536, 65536, 0}, 0, none});
    rows.push_back('{'{-65536, -65536, 0}, 0, none});
    rows.push_back('{'{6, 0, 0}, 0, none});
    rows.push_back('{'{7, 0, 0}, 0, none});
    rows.push_back('{'{100, 0, 0}, 0, none});
    rows.push_back('{'{-1, 0, 0}, 0, none});
    rows.push_back('{'{32'sh80000000, 32'sh80000000, 32'sh80000000}, 0, none});
    rows.push_back('{'{32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff}, 0, none});
    rows.push_back('{'{-65536, 3, 0}, 0, none});
    foreach (rows[i]) send_cmd(rows[i].cmd, rows[i].typed, rows[i].want);
    drain_results();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin
          cfg_write(REG_WHEEL0_X, 19661);
          cfg_write(REG_WHEEL0_Y, -19661);
          cfg_write(REG_WHEEL1_X, -19661);
          cfg_write(REG_WHEEL1_Y, 19661);
          cfg_write(REG_INV_RADIUS, 655360);
        end
        1: begin
          cfg_write(REG_WHEEL0_X, 32'h7fffffff);
          cfg_write(REG_WHEEL0_Y, 32'h80000000);
          cfg_write(REG_WHEEL1_X, 32'h80000000);
          cfg_write(REG_WHEEL1_Y, 32'h7fffffff);
          cfg_write(REG_INV_RADIUS, 65536000);
        end
        2: begin
          for (int r = 0; r < 4; r++) begin
            cfg_write(CfgIdxW'(r), $urandom_range(0, 131072) - 65536);
          end
          cfg_write(REG_INV_RADIUS, 0);
        end
        3: begin
          for (int r = 0; r < 4; r++) begin
            cfg_write(CfgIdxW'(r), $urandom_range(0, 65536) - 32768);
          end
          cfg_write(REG_INV_RADIUS, 1);
        end
        4: begin
          for (int r = 0; r < 4; r++) cfg_write(CfgIdxW'(r), $urandom);
          cfg_write(REG_INV_RADIUS, $urandom_range(1, 65536000));
        end
        default: begin
          for (int r = 0; r < 4; r++) begin
            cfg_write(CfgIdxW'(r), $urandom_range(0, 65536) - 32768);
          end
          cfg_write(REG_INV_RADIUS, $urandom_range(1, 2000000));
        end
      endcase
      cfg_we_i <= 1'b0;
      idle_mode = ph % 4;
      for (int n = 0; n < 150; n++) begin
        if (ph == 4 && n == 20) hold_req = 1'b1;
        if ($urandom_range(0, 9) == 0) begin
          c = last_cmd;
        end else begin
          c.body_vx = rand_velocity();
          c.body_vy = rand_velocity();
          c.body_wz = rand_velocity();
        end
        last_cmd = c;
        send_cmd(c, 1'b0, none);
        if (ph == 5 && n == 75) drain_results();
      end
      drain_results();
      repeat (150) @(posedge clk_i);
    end

    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("[swerve_inverse_kinematics] OK");
    else $display("[swerve_inverse_kinematics] ERROR");
    $finish;
  end

  initial begin
    wheel_if.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = 400;
      end
      if (hold_left > 0) begin
        hold_left--;
        wheel_if.ready <= 1'b0;
      end else if (idle_mode == 2) begin
        wheel_if.ready <= ($urandom_range(0, 99) >= 46);
      end else if (idle_mode == 3) begin
        wheel_if.ready <= ($urandom_range(0, 99) >= 10);
      end else begin
        wheel_if.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && wheel_if.valid && wheel_if.ready) begin
      if (pending_wheels.size() == 0) begin
        report("unexpected word", wheel_if.data.angle0, 0);
      end else begin
        want = pending_wheels.pop_front();
        if (wheel_if.data.angle0 !== want.angle0) report("angle0", wheel_if.data.angle0, want.angle0);
        if (wheel_if.data.speed0 !== want.speed0) report("speed0", wheel_if.data.speed0, want.speed0);
        if (wheel_if.data.angle1 !== want.angle1) report("angle1", wheel_if.data.angle1, want.angle1);
        if (wheel_if.data.speed1 !== want.speed1) report("speed1", wheel_if.data.speed1, want.speed1);
      end
    end
  end

endmodule
